>>> sv/fmpf_pkg.sv
// ----------------------------------------------------------------------------
// fmpf_pkg
// Shared types and constants of the first-match packet filter: rule table
// geometry, command codes, control word layout and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package fmpf_pkg;

  // Rule table geometry
  localparam int NUM_RULES = 64;
  localparam int IDX_W     = 6;
  localparam int SCAN_W    = IDX_W + 1;
  localparam int NUM_WORDS = 7;
  localparam int WSEL_W    = 3;
  localparam int WORD_W    = 32;
  localparam int PORT_W    = 16;
  localparam int PROTO_W   = 8;
  localparam int ACT_W     = 2;
  localparam int CMD_W     = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

  // Word selects
  localparam logic [WSEL_W-1:0] WSEL_SRC_ADDR = 3'd0;
  localparam logic [WSEL_W-1:0] WSEL_SRC_MASK = 3'd1;
  localparam logic [WSEL_W-1:0] WSEL_DST_ADDR = 3'd2;
  localparam logic [WSEL_W-1:0] WSEL_DST_MASK = 3'd3;
  localparam logic [WSEL_W-1:0] WSEL_SRC_PORT = 3'd4;
  localparam logic [WSEL_W-1:0] WSEL_DST_PORT = 3'd5;
  localparam logic [WSEL_W-1:0] WSEL_CTRL     = 3'd6;

  // Control word bit positions
  localparam int CTL_VALID  = 0;
  localparam int CTL_EN     = 1;
  localparam int CTL_CHAIN  = 2;
  localparam int CTL_PROTO  = 3;
  localparam int CTL_ACTION = 11;

  // Action codes (anything but allow denies)
  localparam logic [ACT_W-1:0] ACT_ALLOW = 2'd0;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture item, clear result, restart scan
    logic wr_rule;   // write the captured rule word
    logic scan_run;  // advance the scan pointer
    logic take_hit;  // record the first matching rule
    logic cnt_upd;   // counter read-out or increment
  } fmpf_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic enable;    // filter_enable register
    logic hit;       // rule under evaluation matches
    logic last;      // last rule is under evaluation
  } fmpf_sts_t;

endpackage

>>> sv/fmpf_ctrl.sv
// ----------------------------------------------------------------------------
// fmpf_ctrl
// Sequencer of the packet filter: accepts one command at a time, walks the
// rule scan, the counter read-modify-write and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module fmpf_ctrl import fmpf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CMD_W-1:0] in_cmd,
  input  fmpf_sts_t        sts,
  output fmpf_cmd_t        cmd,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_WRITE   = 6'b000100,
    S_CNT_RD  = 6'b001000,
    S_CNT_UPD = 6'b010000,
    S_RESULT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_cmd)
            CMD_CLASSIFY: state_nxt = sts.enable ? S_SCAN : S_RESULT;
            CMD_WRITE:    state_nxt = S_WRITE;
            CMD_READ:     state_nxt = S_CNT_RD;
            default:      state_nxt = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_CNT_RD;
        end else if (sts.last) begin
          state_nxt = S_RESULT;
        end
      end
      S_WRITE: begin
        cmd.wr_rule = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_UPD;
      end
      S_CNT_UPD: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESULT);

endmodule

>>> sv/fmpf_dp.sv
// ----------------------------------------------------------------------------
// fmpf_dp
// Datapath of the packet filter: item capture, rule word memories with a
// one-rule-per-cycle registered read, match evaluation, match counter memory
// and the result registers.
// ----------------------------------------------------------------------------
module fmpf_dp import fmpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  fmpf_cmd_t          cmd,
  output fmpf_sts_t          sts,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [IDX_W-1:0]   in_rule_index,
  input  logic [WSEL_W-1:0]  in_word_select,
  input  logic [WORD_W-1:0]  in_word_data,
  input  logic [WORD_W-1:0]  in_src_address,
  input  logic [WORD_W-1:0]  in_dst_address,
  input  logic [PORT_W-1:0]  in_src_port_in,
  input  logic [PORT_W-1:0]  in_dst_port_in,
  input  logic [PROTO_W-1:0] in_proto_in,
  input  logic               in_outbound,
  output logic               out_verdict,
  output logic               out_matched,
  output logic [IDX_W-1:0]   out_hit_index,
  output logic [ACT_W-1:0]   out_hit_action,
  output logic [WORD_W-1:0]  out_read_data
);

  // Captured item
  logic [CMD_W-1:0]   cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [WSEL_W-1:0]  sel_r;
  logic [WORD_W-1:0]  data_r;
  logic [WORD_W-1:0]  sa_r;
  logic [WORD_W-1:0]  da_r;
  logic [PORT_W-1:0]  sp_r;
  logic [PORT_W-1:0]  dport_r;
  logic [PROTO_W-1:0] proto_r;
  logic               dir_r;

  logic               en_r;

  // Scan pointer and evaluation stage
  logic [SCAN_W-1:0]  scan_cnt_r;
  logic [IDX_W-1:0]   scan_idx;
  logic               eval_valid_r;
  logic [IDX_W-1:0]   eval_idx_r;

  logic [NUM_RULES-1:0] rule_vld_r;
  logic                 rule_vld_q_r;
  logic [WORD_W-1:0]    word_q [NUM_WORDS];

  // Match counters
  logic [WORD_W-1:0]    cnt_mem [NUM_RULES];
  logic [NUM_RULES-1:0] cnt_vld_r;
  logic [WORD_W-1:0]    cnt_q_r;
  logic                 cnt_qv_r;
  logic [IDX_W-1:0]     cnt_addr;
  logic [WORD_W-1:0]    cnt_cur;

  // Result registers
  logic               verdict_r;
  logic               matched_r;
  logic [IDX_W-1:0]   hit_r;
  logic [ACT_W-1:0]   act_r;
  logic [WORD_W-1:0]  rdata_r;

  // Match terms
  logic [WORD_W-1:0]  ctl;
  logic [PROTO_W-1:0] rule_proto;
  logic [ACT_W-1:0]   rule_act;
  logic               sel_ok, proto_ok, sa_ok, da_ok, sp_ok, dp_ok;

  assign scan_idx = scan_cnt_r[IDX_W-1:0];

  // Filter enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
    end else if (cfg_we) begin
      en_r <= cfg_wdata;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      idx_r   <= in_rule_index;
      sel_r   <= in_word_select;
      data_r  <= in_word_data;
      sa_r    <= in_src_address;
      da_r    <= in_dst_address;
      sp_r    <= in_src_port_in;
      dport_r <= in_dst_port_in;
      proto_r <= in_proto_in;
      dir_r   <= in_outbound;
    end
  end

  // Scan pointer; one rule read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      eval_valid_r <= 1'b0;
    end else if (cmd.load) begin
      scan_cnt_r   <= '0;
      eval_valid_r <= 1'b0;
    end else begin
      eval_valid_r <= cmd.scan_run && (scan_cnt_r < SCAN_W'(NUM_RULES));
      if (cmd.scan_run && (scan_cnt_r < SCAN_W'(NUM_RULES))) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= scan_idx;
  end

  // Rule word memories, one per word select
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    logic [WORD_W-1:0] mem [NUM_RULES];
    always_ff @(posedge clk) begin
      if (cmd.wr_rule && (sel_r == WSEL_W'(w))) begin
        mem[idx_r] <= data_r;
      end
      word_q[w] <= mem[scan_idx];
    end
  end

  // Rule valid bits, set by control word writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_vld_r <= '0;
    end else if (cmd.wr_rule && (sel_r == WSEL_CTRL)) begin
      rule_vld_r[idx_r] <= data_r[CTL_VALID];
    end
  end

  always_ff @(posedge clk) begin
    rule_vld_q_r <= rule_vld_r[scan_idx];
  end

  // Match evaluation of the rule read last cycle
  always_comb begin
    ctl        = word_q[WSEL_CTRL];
    rule_proto = ctl[CTL_PROTO +: PROTO_W];
    rule_act   = ctl[CTL_ACTION +: ACT_W];
    sel_ok     = rule_vld_q_r && ctl[CTL_EN] && (ctl[CTL_CHAIN] == dir_r);
    proto_ok   = (rule_proto == '0) || (rule_proto == proto_r);
    sa_ok      = (word_q[WSEL_SRC_ADDR] == '0) ||
                 ((sa_r & word_q[WSEL_SRC_MASK]) == word_q[WSEL_SRC_ADDR]);
    da_ok      = (word_q[WSEL_DST_ADDR] == '0) ||
                 ((da_r & word_q[WSEL_DST_MASK]) == word_q[WSEL_DST_ADDR]);
    sp_ok      = (sp_r >= word_q[WSEL_SRC_PORT][PORT_W-1:0]) &&
                 (sp_r <= word_q[WSEL_SRC_PORT][WORD_W-1:PORT_W]);
    dp_ok      = (dport_r >= word_q[WSEL_DST_PORT][PORT_W-1:0]) &&
                 (dport_r <= word_q[WSEL_DST_PORT][WORD_W-1:PORT_W]);
  end

  assign sts.enable = en_r;
  assign sts.hit    = eval_valid_r && sel_ok && proto_ok && sa_ok && da_ok && sp_ok && dp_ok;
  assign sts.last   = eval_valid_r && (eval_idx_r == IDX_W'(NUM_RULES - 1));

  // Counter memory: read at the hit rule or the requested slot
  assign cnt_addr = (cmd_r == CMD_READ) ? idx_r : hit_r;
  assign cnt_cur  = cnt_qv_r ? cnt_q_r : '0;

  always_ff @(posedge clk) begin
    cnt_q_r  <= cnt_mem[cnt_addr];
    cnt_qv_r <= cnt_vld_r[cnt_addr];
    if (cmd.cnt_upd && (cmd_r == CMD_CLASSIFY)) begin
      cnt_mem[cnt_addr] <= cnt_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cmd.cnt_upd && (cmd_r == CMD_CLASSIFY)) begin
      cnt_vld_r[cnt_addr] <= 1'b1;
    end
  end

  // Result registers; default verdict follows the chain and the filter enable
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      verdict_r <= (in_cmd == CMD_CLASSIFY) && en_r && !in_outbound;
      matched_r <= 1'b0;
      hit_r     <= '0;
      act_r     <= '0;
      rdata_r   <= '0;
    end else if (cmd.take_hit) begin
      verdict_r <= (rule_act != ACT_ALLOW);
      matched_r <= 1'b1;
      hit_r     <= eval_idx_r;
      act_r     <= rule_act;
    end else if (cmd.cnt_upd && (cmd_r == CMD_READ)) begin
      rdata_r <= cnt_cur;
    end
  end

  assign out_verdict    = verdict_r;
  assign out_matched    = matched_r;
  assign out_hit_index  = hit_r;
  assign out_hit_action = act_r;
  assign out_read_data  = rdata_r;

endmodule

>>> sv/first_match_packet_filter_top.sv
// ----------------------------------------------------------------------------
// first_match_packet_filter_top
// First-match packet filter: rule table load, classify scan with per-rule
// match counters, and counter read-out.
//
//   channel  handshake          payload
//   -------  -----------------  -----------------------------------------
//   input    start / busy       in_cmd .. in_outbound, one transfer when
//                               start is high and busy is low
//   result   out_valid strobe   out_verdict .. out_read_data, one cycle
//   config   cfg_we             cfg_wdata (filter enable), no wait
//
// Classify scans one rule per cycle out of the rule word memories; a hit
// stops the scan and runs the counter read-modify-write, no match runs the
// full scan, and a disabled filter or unused command goes straight to the
// result. A rule word write passes through its write state, a counter read
// through the counter memory read and register.
// Reset is synchronous; valid bits and counters clear at once, no sweep.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module first_match_packet_filter_top import fmpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [IDX_W-1:0]   in_rule_index,
  input  logic [WSEL_W-1:0]  in_word_select,
  input  logic [WORD_W-1:0]  in_word_data,
  input  logic [WORD_W-1:0]  in_src_address,
  input  logic [WORD_W-1:0]  in_dst_address,
  input  logic [PORT_W-1:0]  in_src_port_in,
  input  logic [PORT_W-1:0]  in_dst_port_in,
  input  logic [PROTO_W-1:0] in_proto_in,
  input  logic               in_outbound,
  output logic               out_valid,
  output logic               out_verdict,
  output logic               out_matched,
  output logic [IDX_W-1:0]   out_hit_index,
  output logic [ACT_W-1:0]   out_hit_action,
  output logic [WORD_W-1:0]  out_read_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  fmpf_cmd_t cmd;
  fmpf_sts_t sts;

  // Sequencer
  fmpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath
  fmpf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_cmd),
    .in_rule_index  (in_rule_index),
    .in_word_select (in_word_select),
    .in_word_data   (in_word_data),
    .in_src_address (in_src_address),
    .in_dst_address (in_dst_address),
    .in_src_port_in (in_src_port_in),
    .in_dst_port_in (in_dst_port_in),
    .in_proto_in    (in_proto_in),
    .in_outbound    (in_outbound),
    .out_verdict    (out_verdict),
    .out_matched    (out_matched),
    .out_hit_index  (out_hit_index),
    .out_hit_action (out_hit_action),
    .out_read_data  (out_read_data)
  );

  // An accepted transfer always leaves the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // Result strobe is a single cycle and ends the command
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  // No match means no rule index or action reported
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_hit_index == '0 && out_hit_action == '0)
    else $error("hit fields set without a match");

  // Counter read-out never carries a classify verdict
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != '0 |-> !out_matched && !out_verdict)
    else $error("counter read with classify fields set");

endmodule
